// ----- rtl/prince_pkg.sv -----
package prince_pkg;

   localparam int BLOCK_WIDTH     = 64;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int RC_COUNT        = 12;
   localparam int CORE_ROUNDS     = 5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WHITENING_KEY = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CORE_KEY      = 8'd1;

   typedef logic [BLOCK_WIDTH-1:0] block_type;

   typedef struct packed {
      block_type whitening_key;
      block_type core_key;
   } prince_keys_type;

   localparam block_type ROUND_CONST [RC_COUNT] = '{
      64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
      64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
      64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
      64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
   };

   localparam logic [3:0] SBOX [16] = '{
      4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
      4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
   };

   localparam logic [3:0] SBOX_INV [16] = '{
      4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
      4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
   };

   // Output nibble i takes input nibble PERM[i]; nibble 0 is the top nibble.
   localparam logic [3:0] SHIFT_ROWS [16] = '{
      4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
      4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
   };

   localparam logic [3:0] SHIFT_ROWS_INV [16] = '{
      4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
      4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
   };

   function automatic block_type sub_layer(input block_type x, input logic inverse);
      block_type y;
      y = '0;
      for (int n = 0; n < 16; n++) begin
         if (inverse) begin
            y[60-4*n +: 4] = SBOX_INV[x[60-4*n +: 4]];
         end else begin
            y[60-4*n +: 4] = SBOX[x[60-4*n +: 4]];
         end
      end
      return y;
   endfunction

   function automatic block_type shift_rows(input block_type x, input logic inverse);
      block_type y;
      int src;
      y = '0;
      for (int n = 0; n < 16; n++) begin
         src = inverse ? int'(SHIFT_ROWS_INV[n]) : int'(SHIFT_ROWS[n]);
         y[60-4*n +: 4] = x[60-4*src +: 4];
      end
      return y;
   endfunction

   // M' is diag(M0, M1, M1, M0) over the four 16-bit chunks.
   function automatic block_type mprime(input block_type x);
      block_type y;
      int c;
      int r;
      int b;
      int off;
      logic acc;
      y = '0;
      for (int p = 0; p < 64; p++) begin
         c   = p / 16;
         r   = (p / 4) % 4;
         b   = p % 4;
         off = (c == 1 || c == 2) ? 1 : 0;
         acc = 1'b0;
         for (int j = 0; j < 4; j++) begin
            if (((r + j + off) % 4) != b) begin
               acc = acc ^ x[63 - (16*c + 4*j + b)];
            end
         end
         y[63-p] = acc;
      end
      return y;
   endfunction

endpackage

// ----- rtl/prince_block_encrypt.sv -----
// Channel   Direction  Payload
// req_      in         tdata[63:0] plaintext
// rsp_      out        tdata[63:0] ciphertext
// csr_      in         index 0 whitening key (k0), index 1 core key (k1), data[63:0]
//
// Each block passes through one input register, then the full twelve-round cipher
// in logic ahead of the result register.
// A new block is taken every cycle while no result stalls; one cipher path sets throughput.
// Reset is synchronous and clears both keys and the valid flags.
// A stalled result holds in its register; the input register keeps filling until both fill.
module prince_block_encrypt (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  prince_pkg::block_type                   req_tdata,   // [63:0] plaintext
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output prince_pkg::block_type                   rsp_tdata,   // [63:0] ciphertext
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [prince_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  prince_pkg::block_type                   csr_data
);
   import prince_pkg::*;

   prince_keys_type keys;
   block_type       core_out;
   block_type       req_data_ff;
   logic            req_valid_ff;
   block_type       rsp_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_free;
   logic            advance;

   prince_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .keys      (keys)
   );

   prince_core u_core (
      .plaintext  (req_data_ff),
      .keys       (keys),
      .ciphertext (core_out)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && rsp_free;
   assign req_tready = !req_valid_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= core_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_advance_loads_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_data_ff == $past(core_out))
      else $error("Result register did not take the cipher output.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && req_valid_ff |=> $stable(rsp_data_ff) && req_valid_ff)
      else $error("A pending block was lost during a stall.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !req_valid_ff)
      else $error("Valid flags not cleared by reset.");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_free |=> $stable(req_data_ff))
      else $error("Input register changed while its block was stalled.");

endmodule

// ----- rtl/prince_csr.sv -----
module prince_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [prince_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  prince_pkg::block_type                   csr_data,
   output prince_pkg::prince_keys_type             keys
);
   import prince_pkg::*;

   prince_keys_type keys_ff;
   prince_keys_type keys_in;

   always_comb begin
      keys_in = keys_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WHITENING_KEY: keys_in.whitening_key = csr_data;
            CSR_CORE_KEY:      keys_in.core_key      = csr_data;
            default:           keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign csr_ready = 1'b1;
   assign keys      = keys_ff;

endmodule

// ----- rtl/prince_core.sv -----
module prince_core (
   input  prince_pkg::block_type         plaintext,
   input  prince_pkg::prince_keys_type   keys,
   output prince_pkg::block_type         ciphertext
);
   import prince_pkg::*;

   block_type k0;
   block_type k1;
   block_type k0_prime;
   block_type fwd_state [CORE_ROUNDS+1];
   block_type bwd_state [CORE_ROUNDS+1];
   block_type middle;

   assign k0       = keys.whitening_key;
   assign k1       = keys.core_key;
   assign k0_prime = {k0[0], k0[63:1]} ^ {63'd0, k0[63]};

   assign fwd_state[0] = plaintext ^ k0 ^ k1 ^ ROUND_CONST[0];

   for (genvar i = 0; i < CORE_ROUNDS; i++) begin : g_fwd
      assign fwd_state[i+1] = shift_rows(mprime(sub_layer(fwd_state[i], 1'b0)), 1'b0)
                              ^ ROUND_CONST[i+1] ^ k1;
   end

   assign middle       = sub_layer(mprime(sub_layer(fwd_state[CORE_ROUNDS], 1'b0)), 1'b1);
   assign bwd_state[0] = middle;

   for (genvar i = 0; i < CORE_ROUNDS; i++) begin : g_bwd
      assign bwd_state[i+1] = sub_layer(mprime(shift_rows(
                                 bwd_state[i] ^ k1 ^ ROUND_CONST[CORE_ROUNDS+1+i], 1'b1)), 1'b1);
   end

   assign ciphertext = bwd_state[CORE_ROUNDS] ^ ROUND_CONST[RC_COUNT-1] ^ k1 ^ k0_prime;

endmodule
